// ===== src/gf2_poly_inverse_ext_euclid_assert.svh =====
// ----------------------------------------------------------------------------
// GF(2) polynomial inverse: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low. ASSERT_OFF drops them.
// ----------------------------------------------------------------------------
`ifndef GF2_POLY_INVERSE_EXT_EUCLID_ASSERT_SVH
`define GF2_POLY_INVERSE_EXT_EUCLID_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication or plain property.
`define GPI_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gpi assertion failed");
// Condition in one cycle implies a consequence in the next.
`define GPI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("gpi assertion failed");
`else
`define GPI_ASSERT(name, prop)
`define GPI_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== src/gpi_pkg.sv =====
// ----------------------------------------------------------------------------
// gpi_pkg
// Shared constants and types of the GF(2) polynomial inverse block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpi_pkg;

    // Width of the element, modulus and inverse words on the ports
    localparam int FIELD_W = 32;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_MODULUS = 1'b0;  // word index of the modulus register
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd283;

    // Result word handed from the engine to the top level
    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] inverse;
        logic               invertible;
    } t_result;

endpackage

// ===== src/gpi_apb_regs.sv =====
// ----------------------------------------------------------------------------
// gpi_apb_regs
// APB-style register file holding the modulus polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpi_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gpi_pkg::APB_AW-1:0]   paddr,
    input  logic [gpi_pkg::APB_DW-1:0]   pwdata,
    output logic [gpi_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [gpi_pkg::FIELD_W-1:0]  o_modulus
);

    logic [gpi_pkg::FIELD_W-1:0] r_modulus;
    logic [gpi_pkg::FIELD_W-1:0] n_modulus;
    logic                        wr_en;
    logic                        sel_modulus;

    assign pready      = 1'b1;
    assign sel_modulus = (paddr[gpi_pkg::APB_AW-1:2] == gpi_pkg::REG_MODULUS);
    assign wr_en       = psel && penable && pwrite && pready;

    always_comb begin
        n_modulus = r_modulus;
        if (wr_en && sel_modulus) begin
            n_modulus = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= gpi_pkg::MODULUS_RESET;
        end else begin
            r_modulus <= n_modulus;
        end
    end

    // Unmapped addresses read as zero
    assign prdata    = sel_modulus ? r_modulus : '0;
    assign o_modulus = r_modulus;

endmodule

// ===== src/gpi_engine.sv =====
// ----------------------------------------------------------------------------
// gpi_engine
// Sequenced extended Euclid: one shift/XOR division step per cycle, with
// the quotient bits folded MSB first into the Bezout product on the fly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gf2_poly_inverse_ext_euclid_assert.svh"

module gpi_engine #(
    parameter int POLY_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gpi_pkg::FIELD_W-1:0]  i_modulus,
    input  logic [gpi_pkg::FIELD_W-1:0]  i_element,
    output logic                         o_busy,
    output gpi_pkg::t_result             o_res
);

    localparam int PW = POLY_WIDTH;
    localparam int FW = gpi_pkg::FIELD_W;
    localparam int XW = (PW > FW) ? PW : FW;
    localparam int CW = (PW > 2) ? $clog2(PW) : 1;
    localparam int RW = $clog2(PW + 2);
    localparam logic [RW-1:0] LAST_RND = RW'(PW + 1);
    localparam logic [PW-1:0] ONE_W    = PW'(1);
    localparam logic [PW-1:0] TOP_BIT  = ONE_W << (PW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_num,   n_num;     // dividend, becomes the remainder
    logic [PW-1:0] r_b,     n_b;       // divisor of this round
    logic [PW-1:0] r_dsh,   n_dsh;     // divisor aligned under the scan bit
    logic [PW-1:0] r_top,   n_top;     // upper bound on the dividend degree
    logic [PW-1:0] r_msk,   n_msk;     // one-hot scan position
    logic [PW-1:0] r_acc,   n_acc;     // running q * w_cur
    logic [PW-1:0] r_wp,    n_wp;
    logic [PW-1:0] r_wc,    n_wc;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [RW-1:0] r_rnd,   n_rnd;
    logic          r_res_valid, n_res_valid;
    logic [FW-1:0] r_res_inv,   n_res_inv;
    logic          r_res_flag,  n_res_flag;

    logic [XW-1:0] mod_ext;
    logic [XW-1:0] elem_ext;
    logic [XW-1:0] wc_ext;
    logic [PW-1:0] mod_w;
    logic [PW-1:0] elem_w;
    logic          hit;
    logic [PW-1:0] step_num;
    logic [PW-1:0] step_acc;
    logic          gcd_one;

    assign mod_ext  = XW'(i_modulus);
    assign elem_ext = XW'(i_element);
    assign wc_ext   = XW'(r_wc);
    assign mod_w    = mod_ext[PW-1:0];
    assign elem_w   = elem_ext[PW-1:0];

    // Shared shift/XOR unit: one long-division step and one Horner step
    assign hit      = |(r_num & r_msk);
    assign step_num = hit ? (r_num ^ r_dsh) : r_num;
    assign step_acc = (r_acc << 1) ^ (hit ? r_wc : '0);
    assign gcd_one  = (r_num == ONE_W);

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_b         = r_b;
        n_dsh       = r_dsh;
        n_top       = r_top;
        n_msk       = r_msk;
        n_acc       = r_acc;
        n_wp        = r_wp;
        n_wc        = r_wc;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_res_valid = 1'b0;
        n_res_inv   = r_res_inv;
        n_res_flag  = r_res_flag;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_num   = mod_w;
                    n_b     = elem_w;
                    n_dsh   = elem_w;
                    n_top   = TOP_BIT;
                    n_wp    = '0;
                    n_wc    = ONE_W;
                    n_cnt   = '0;
                    n_rnd   = '0;
                    n_acc   = '0;
                    n_state = (elem_w == '0) ? ST_FIN : ST_NORM;
                end
            end
            ST_NORM: begin
                // Raise the divisor until its leading bit sits at the dividend top
                if (|(r_dsh & r_top)) begin
                    n_msk   = r_top;
                    n_acc   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_dsh = r_dsh << 1;
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_DIV: begin
                n_num = step_num;
                n_acc = step_acc;
                if (r_cnt == '0) begin
                    if (step_num != '0) begin
                        n_wp = r_wc;
                        n_wc = r_wp ^ step_acc;
                    end
                    n_num   = r_b;
                    n_b     = step_num;
                    n_dsh   = step_num;
                    n_top   = r_msk;  // exact degree of the new dividend
                    n_rnd   = r_rnd + RW'(1);
                    n_state = (step_num == '0 || r_rnd == LAST_RND) ? ST_FIN : ST_NORM;
                end else begin
                    n_dsh = r_dsh >> 1;
                    n_msk = r_msk >> 1;
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ST_FIN: begin
                n_res_valid = 1'b1;
                n_res_inv   = gcd_one ? wc_ext[FW-1:0] : '0;
                n_res_flag  = gcd_one;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rnd       <= n_rnd;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_b        <= n_b;
        r_dsh      <= n_dsh;
        r_top      <= n_top;
        r_msk      <= n_msk;
        r_acc      <= n_acc;
        r_wp       <= n_wp;
        r_wc       <= n_wc;
        r_res_inv  <= n_res_inv;
        r_res_flag <= n_res_flag;
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_res.valid      = r_res_valid;
    assign o_res.inverse    = r_res_inv;
    assign o_res.invertible = r_res_flag;

    `GPI_ASSERT_NEXT(a_fin_strobes, r_state == ST_FIN, r_res_valid)
    `GPI_ASSERT_NEXT(a_start_leaves_idle, i_start && r_state == ST_IDLE, r_state != ST_IDLE)
    `GPI_ASSERT(a_scan_onehot, (r_state == ST_DIV) |-> $onehot(r_msk))
    `GPI_ASSERT(a_divisor_aligned, (r_state == ST_DIV) |-> (|(r_dsh & r_msk) && ((r_dsh & ~(r_msk | (r_msk - ONE_W))) == '0)))
    `GPI_ASSERT(a_zero_when_not_inv, (r_res_valid && !r_res_flag) |-> (r_res_inv == '0))

endmodule

// ===== src/gf2_poly_inverse_ext_euclid.sv =====
// ----------------------------------------------------------------------------
// Sequence: each Euclid round normalises the divisor under the dividend top,
//   then divides one quotient bit per step down to the divisor's degree;
//   a final state registers the result. A zero element goes straight to it.
// Throughput: one word at a time; busy drops in the cycle of the strobe.
// Reset (i_rst_n low, synchronous): sequencer idle, strobe low, modulus 283.
// ----------------------------------------------------------------------------
// gf2_poly_inverse_ext_euclid
// Inverse of a GF(2) polynomial modulo a configured modulus, by the
// extended Euclidean algorithm. Each result word is shown for one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gf2_poly_inverse_ext_euclid #(
    parameter int POLY_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gpi_pkg::APB_AW-1:0]   paddr,
    input  logic [gpi_pkg::APB_DW-1:0]   pwdata,
    output logic [gpi_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [gpi_pkg::FIELD_W-1:0]  i_element_poly,
    output logic                         o_result_valid,
    output logic [gpi_pkg::FIELD_W-1:0]  o_inverse_poly,
    output logic                         o_invertible
);

    logic [gpi_pkg::FIELD_W-1:0] modulus;
    gpi_pkg::t_result            res;

    gpi_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (modulus)
    );

    gpi_engine #(
        .POLY_WIDTH (POLY_WIDTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_modulus (modulus),
        .i_element (i_element_poly),
        .o_busy    (busy),
        .o_res     (res)
    );

    assign o_result_valid = res.valid;
    assign o_inverse_poly = res.inverse;
    assign o_invertible   = res.invertible;

endmodule
